// ----- hdl/kfreq_pkg.sv -----
package kfreq_pkg;

    typedef logic [1:0] t_cmd;
    typedef logic [1:0] t_status;

    // commands carried in s_axis_tuser
    localparam t_cmd CMD_COUNT = 2'd0;
    localparam t_cmd CMD_QUERY = 2'd1;
    localparam t_cmd CMD_READ  = 2'd2;

    // status codes carried in m_axis_tuser
    localparam t_status STAT_OK        = 2'd0;
    localparam t_status STAT_FULL      = 2'd1;
    localparam t_status STAT_BAD_INDEX = 2'd2;

    // field widths of the stream payloads
    localparam int KEY_FIELD_W   = 64;
    localparam int INDEX_FIELD_W = 6;
    localparam int FREQ_FIELD_W  = 16;
    localparam int USED_FIELD_W  = 7;

    localparam int S_TDATA_W = 72;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 88;
    localparam int M_TUSER_W = 3;

endpackage

// ----- hdl/key_frequency_table_top.sv -----
// Key frequency table: keeps up to TABLE_ENTRIES distinct keys with an occurrence count each,
// in order of first appearance, in one synchronous memory (key and count side by side). Only
// the high KEY_BYTES bytes of a key take part. A count request walks the filled entries one
// memory read per cycle: a hit increments the count (saturating) and writes it back, a miss
// appends the key with count 1 or reports full. A query walks the same way without writing;
// a read by index takes a single memory read, and an invalid index or an unused command goes
// straight to the result. The next request is taken the cycle after the result register is
// loaded, so a request must finish its memory walk, one entry per cycle, before the next one
// is taken. The result register lets a new request start while the previous result still
// waits on m_axis_tready.
module key_frequency_table_top #(
    parameter int TABLE_ENTRIES = 64,
    parameter int KEY_BYTES     = 8,
    parameter int COUNT_BITS    = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // key [63:0], entry_index [69:64], zero pad [71:70]
    input  logic [kfreq_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // command [1:0]
    input  logic [kfreq_pkg::S_TUSER_W-1:0] s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // frequency [15:0], entry_key [79:16], entries_used [86:80], zero pad [87]
    output logic [kfreq_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // status [1:0], found [2]
    output logic [kfreq_pkg::M_TUSER_W-1:0] m_axis_tuser
);
    import kfreq_pkg::*;

    localparam int KEY_W = 8 * KEY_BYTES;
    localparam int AW    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int FW    = $clog2(TABLE_ENTRIES + 1);
    localparam int MEM_W = KEY_W + COUNT_BITS;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SEARCH = 3'd1;
    localparam logic [2:0] ST_READ   = 3'd2;
    localparam logic [2:0] ST_MISS   = 3'd3;
    localparam logic [2:0] ST_RESULT = 3'd4;

    // table memory: key in the high bits, count in the low bits
    logic [MEM_W-1:0] r_mem [TABLE_ENTRIES];
    logic [MEM_W-1:0] r_rd;

    logic [2:0]      r_state, n_state;
    logic [FW-1:0]   r_fill, n_fill;
    logic [AW-1:0]   r_chk, n_chk;
    t_cmd            r_cmd, n_cmd;
    logic [KEY_W-1:0] r_key, n_key;

    t_status                 r_res_status, n_res_status;
    logic                    r_res_found, n_res_found;
    logic [FREQ_FIELD_W-1:0] r_res_freq, n_res_freq;
    logic [KEY_FIELD_W-1:0]  r_res_ekey, n_res_ekey;

    logic                    r_out_valid;
    t_status                 r_out_status;
    logic                    r_out_found;
    logic [FREQ_FIELD_W-1:0] r_out_freq;
    logic [KEY_FIELD_W-1:0]  r_out_ekey;
    logic [USED_FIELD_W-1:0] r_out_used;

    logic                  mem_we;
    logic [AW-1:0]         mem_wa;
    logic [MEM_W-1:0]      mem_wd;
    logic [AW-1:0]         mem_ra;

    t_cmd                   in_cmd;
    logic [KEY_FIELD_W-1:0] in_key;
    logic [INDEX_FIELD_W-1:0] in_idx;
    logic                   in_accept;

    logic [KEY_W-1:0]      rd_key;
    logic [COUNT_BITS-1:0] rd_cnt;
    logic [COUNT_BITS-1:0] rd_cnt_inc;
    logic                  rd_hit;
    logic                  chk_last;
    logic                  out_free;

    assign in_cmd = s_axis_tuser[1:0];
    assign in_key = s_axis_tdata[KEY_FIELD_W-1:0];
    assign in_idx = s_axis_tdata[KEY_FIELD_W +: INDEX_FIELD_W];

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;

    assign rd_key     = r_rd[MEM_W-1:COUNT_BITS];
    assign rd_cnt     = r_rd[COUNT_BITS-1:0];
    assign rd_cnt_inc = (rd_cnt == '1) ? rd_cnt : rd_cnt + COUNT_BITS'(1);
    assign rd_hit     = (rd_key == r_key);
    assign chk_last   = (FW'(r_chk) + FW'(1)) == r_fill;

    always_comb begin
        n_state      = r_state;
        n_fill       = r_fill;
        n_chk        = r_chk;
        n_cmd        = r_cmd;
        n_key        = r_key;
        n_res_status = r_res_status;
        n_res_found  = r_res_found;
        n_res_freq   = r_res_freq;
        n_res_ekey   = r_res_ekey;
        mem_we       = 1'b0;
        mem_wa       = r_chk;
        mem_wd       = {r_key, rd_cnt_inc};
        mem_ra       = r_chk + AW'(1);

        unique case (r_state)
            ST_IDLE: begin
                mem_ra = '0;
                if (in_accept) begin
                    n_cmd        = in_cmd;
                    n_key        = in_key[KEY_FIELD_W-1 -: KEY_W];
                    n_chk        = '0;
                    n_res_status = STAT_OK;
                    n_res_found  = 1'b0;
                    n_res_freq   = '0;
                    n_res_ekey   = '0;
                    case (in_cmd)
                        CMD_COUNT, CMD_QUERY: begin
                            n_state = (r_fill == '0) ? ST_MISS : ST_SEARCH;
                        end
                        CMD_READ: begin
                            mem_ra = AW'(in_idx);
                            if (32'(in_idx) < 32'(r_fill)) begin
                                n_state = ST_READ;
                            end else begin
                                n_res_status = STAT_BAD_INDEX;
                                n_state      = ST_RESULT;
                            end
                        end
                        default: begin
                            n_state = ST_RESULT;
                        end
                    endcase
                end
            end
            ST_SEARCH: begin
                // r_rd holds entry r_chk, the read of r_chk + 1 is in flight
                if (rd_hit) begin
                    n_res_found = 1'b1;
                    if (r_cmd == CMD_COUNT) begin
                        mem_we     = 1'b1;
                        n_res_freq = FREQ_FIELD_W'(rd_cnt_inc);
                    end else begin
                        n_res_freq = FREQ_FIELD_W'(rd_cnt);
                    end
                    n_state = ST_RESULT;
                end else if (chk_last) begin
                    n_state = ST_MISS;
                end else begin
                    n_chk = r_chk + AW'(1);
                end
            end
            ST_MISS: begin
                if (r_cmd == CMD_COUNT) begin
                    if (r_fill < FW'(TABLE_ENTRIES)) begin
                        mem_we     = 1'b1;
                        mem_wa     = AW'(r_fill);
                        mem_wd     = {r_key, COUNT_BITS'(1)};
                        n_fill     = r_fill + FW'(1);
                        n_res_freq = FREQ_FIELD_W'(1);
                    end else begin
                        n_res_status = STAT_FULL;
                    end
                end
                n_state = ST_RESULT;
            end
            ST_READ: begin
                n_res_found = 1'b1;
                n_res_freq  = FREQ_FIELD_W'(rd_cnt);
                n_res_ekey  = KEY_FIELD_W'(rd_key) << (KEY_FIELD_W - KEY_W);
                n_state     = ST_RESULT;
            end
            ST_RESULT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd <= r_mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            if (r_state == ST_RESULT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_chk        <= n_chk;
        r_cmd        <= n_cmd;
        r_key        <= n_key;
        r_res_status <= n_res_status;
        r_res_found  <= n_res_found;
        r_res_freq   <= n_res_freq;
        r_res_ekey   <= n_res_ekey;
        if (r_state == ST_RESULT && out_free) begin
            r_out_status <= r_res_status;
            r_out_found  <= r_res_found;
            r_out_freq   <= r_res_freq;
            r_out_ekey   <= r_res_ekey;
            r_out_used   <= USED_FIELD_W'(r_fill);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_used, r_out_ekey, r_out_freq};
    assign m_axis_tuser  = {r_out_found, r_out_status};

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_fill) <= TABLE_ENTRIES)
        else $error("fill level beyond table size");

    a_fill_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && (r_fill != $past(r_fill)) |->
            (r_fill == $past(r_fill) + FW'(1)) && ($past(r_state) == ST_MISS))
        else $error("fill level moved other than by one append");

    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == ST_SEARCH || r_state == ST_MISS) && (r_cmd == CMD_COUNT))
        else $error("table write outside a count request");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $rose(r_out_valid) |-> $past(r_state) == ST_RESULT)
        else $error("result shown without a finished request");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_found |-> r_out_status == STAT_OK)
        else $error("found flag with an error status");

endmodule

// ----- verif/testbench.sv -----
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import kfreq_pkg::*;

    localparam int TABLE_ENTRIES = 64;
    localparam int KEY_BYTES     = 8;
    localparam int COUNT_BITS    = 16;

    localparam logic [63:0] KEY_MASK   = ~64'd0 << (64 - 8 * KEY_BYTES);
    localparam logic [31:0] COUNT_MAX  = 32'((33'd1 << COUNT_BITS) - 1);
    localparam logic [63:0] KEY_ONES   = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam t_cmd        CMD_UNUSED = 2'd3;
    localparam int          POOL_SIZE  = 80;
    localparam int          CYCLE_LIMIT = 2_000_000;
    localparam int          MAX_REPORTS = 10;

    typedef struct packed {
        t_status     status;
        logic        found;
        logic [15:0] frequency;
        logic [63:0] entry_key;
        logic [6:0]  entries_used;
    } t_reply;

    class t_tracker;
        logic [63:0] stored_key [TABLE_ENTRIES];
        logic [31:0] stored_count [TABLE_ENTRIES];
        int unsigned fill_level;
        t_reply      pending_replies [$];
        int unsigned mismatches;
        int unsigned replies_checked;
        int unsigned per_command [4];
        int unsigned full_drops;
        int unsigned bad_reads;
        int unsigned saturated_hits;

        function int unsigned find_key(logic [63:0] key);
            for (int unsigned i = 0; i < fill_level; i++) begin
                if (stored_key[i] == key) return i;
            end
            return fill_level;
        endfunction

        // predicts the reply to one accepted request and updates the table
        function void note_request(t_cmd cmd, logic [63:0] raw_key, logic [5:0] idx);
            t_reply      want;
            logic [63:0] key;
            int unsigned pos;
            key  = raw_key & KEY_MASK;
            want = '0;
            per_command[cmd]++;
            case (cmd)
                CMD_COUNT: begin
                    pos = find_key(key);
                    if (pos < fill_level) begin
                        if (stored_count[pos] < COUNT_MAX) stored_count[pos]++;
                        else saturated_hits++;
                        want.found     = 1'b1;
                        want.frequency = stored_count[pos][15:0];
                    end else if (fill_level < TABLE_ENTRIES) begin
                        stored_key[fill_level]   = key;
                        stored_count[fill_level] = 32'd1;
                        fill_level++;
                        want.frequency = 16'd1;
                    end else begin
                        want.status = STAT_FULL;
                        full_drops++;
                    end
                end
                CMD_QUERY: begin
                    pos = find_key(key);
                    if (pos < fill_level) begin
                        want.found     = 1'b1;
                        want.frequency = stored_count[pos][15:0];
                    end
                end
                CMD_READ: begin
                    if (idx < fill_level) begin
                        want.found     = 1'b1;
                        want.frequency = stored_count[idx][15:0];
                        want.entry_key = stored_key[idx];
                    end else begin
                        want.status = STAT_BAD_INDEX;
                        bad_reads++;
                    end
                end
                default: ;
            endcase
            want.entries_used = fill_level[6:0];
            pending_replies = {pending_replies, want};
        endfunction

        function void check_result(t_reply got);
            t_reply want;
            logic   bad;
            if (pending_replies.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display({"%0t: reply with nothing pending: ",
                              "status=%0d found=%0d freq=%0d key=%h used=%0d"},
                             $realtime, got.status, got.found, got.frequency, got.entry_key,
                             got.entries_used);
                return;
            end
            want = pending_replies.pop_front();
            replies_checked++;
            bad = (got.status !== want.status) || (got.found !== want.found)
                || (got.frequency !== want.frequency) || (got.entry_key !== want.entry_key)
                || (got.entries_used !== want.entries_used);
            if (bad) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("%0t: reply %0d mismatch", $realtime, replies_checked);
                    $display("  expected status=%0d found=%0d freq=%0d key=%h used=%0d",
                             want.status, want.found, want.frequency, want.entry_key,
                             want.entries_used);
                    $display("  actual   status=%0d found=%0d freq=%0d key=%h used=%0d",
                             got.status, got.found, got.frequency, got.entry_key,
                             got.entries_used);
                end
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;
    logic [S_TUSER_W-1:0] s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [M_TUSER_W-1:0] m_axis_tuser;

    t_tracker         tracker = new();
    int unsigned      send_idle_pct;
    int unsigned      recv_idle_pct;
    int unsigned      cycle_count;
    logic [63:0]      word_pool [POOL_SIZE];

    key_frequency_table_top #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .KEY_BYTES    (KEY_BYTES),
        .COUNT_BITS   (COUNT_BITS)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),   // key [63:0], entry_index [69:64], zero pad [71:70]
        .s_axis_tuser (s_axis_tuser),   // command [1:0]
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),   // frequency [15:0], entry_key [79:16], entries_used [86:80]
        .m_axis_tuser (m_axis_tuser)    // status [1:0], found [2]
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin : watch_replies
        t_reply seen;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen.status       = m_axis_tuser[1:0];
            seen.found        = m_axis_tuser[2];
            seen.frequency    = m_axis_tdata[15:0];
            seen.entry_key    = m_axis_tdata[79:16];
            seen.entries_used = m_axis_tdata[86:80];
            tracker.check_result(seen);
        end
    end

    // lowercase word of 1 to 8 letters, first letter in the top byte
    function automatic logic [63:0] word_key();
        logic [63:0] k;
        int unsigned len;
        k   = '0;
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++) k[63 - 8 * i -: 8] = 8'($urandom_range(97, 122));
        return k;
    endfunction

    function automatic logic [63:0] fresh_key();
        if ($urandom_range(1)) return word_key();
        return {$urandom, $urandom};
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_request(t_cmd cmd, logic [63:0] key, logic [5:0] idx);
        if ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, idx, key};
        s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        tracker.note_request(cmd, key, idx);
        @(negedge i_clk);
    endtask

    task automatic wait_for_replies();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (tracker.pending_replies.size() != 0);
    endtask

    // mostly keys from a shared pool so the table fills and hits repeat
    task automatic random_requests(int unsigned n);
        int unsigned pick;
        t_cmd        cmd;
        logic [63:0] key;
        logic [5:0]  idx;
        repeat (n) begin
            pick = $urandom_range(99);
            if (pick < 45)      cmd = CMD_COUNT;
            else if (pick < 75) cmd = CMD_QUERY;
            else if (pick < 95) cmd = CMD_READ;
            else                cmd = CMD_UNUSED;
            if ($urandom_range(99) < 85) key = word_pool[$urandom_range(POOL_SIZE - 1)];
            else                         key = fresh_key();
            if (cmd == CMD_READ && $urandom_range(99) < 70 && tracker.fill_level > 0)
                idx = 6'($urandom_range(tracker.fill_level - 1));
            else
                idx = 6'($urandom_range(63));
            send_request(cmd, key, idx);
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_COUNT;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < POOL_SIZE; i++)
            word_pool[i] = (i % 4 == 0) ? {$urandom, $urandom} : word_key();

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty table, unused command, extremes of key and index
        send_request(CMD_QUERY,  64'd0, 6'd0);
        send_request(CMD_READ,   64'd0, 6'd0);
        send_request(CMD_READ,   KEY_ONES, 6'd63);
        send_request(CMD_UNUSED, KEY_ONES, 6'd63);
        send_request(CMD_COUNT,  KEY_ONES, 6'd0);
        send_request(CMD_COUNT,  64'd0, 6'd63);
        send_request(CMD_COUNT,  64'hAAAA_AAAA_AAAA_AAAA, 6'd21);
        send_request(CMD_COUNT,  64'h5555_5555_5555_5555, 6'd42);
        send_request(CMD_COUNT,  KEY_ONES, 6'd5);
        send_request(CMD_COUNT,  64'd0, 6'd9);
        send_request(CMD_QUERY,  KEY_ONES, 6'd0);
        send_request(CMD_QUERY,  64'h0123_4567_89AB_CDEF, 6'd0);
        send_request(CMD_READ,   64'd0, 6'd0);
        send_request(CMD_READ,   KEY_ONES, 6'd3);
        send_request(CMD_READ,   64'd0, 6'd4);
        send_request(CMD_UNUSED, 64'd0, 6'd0);
        send_request(CMD_QUERY,  64'd0, 6'd63);
        wait_for_replies();

        // repeated counts of the first entry, no idling on either side
        repeat (40) send_request(CMD_COUNT, KEY_ONES, 6'($urandom_range(63)));
        send_request(CMD_QUERY, KEY_ONES, 6'd0);
        send_request(CMD_READ,  64'd0, 6'd0);
        wait_for_replies();

        send_idle_pct = 25;
        recv_idle_pct = 55;
        random_requests(260);
        wait_for_replies();

        send_idle_pct = 55;
        recv_idle_pct = 25;
        random_requests(260);
        wait_for_replies();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_requests(260);

        // make sure the table is full, then hit the drop path
        while (tracker.fill_level < TABLE_ENTRIES)
            send_request(CMD_COUNT, fresh_key(), 6'($urandom_range(63)));
        send_request(CMD_COUNT, 64'h0123_4567_89AB_CDEF, 6'd0);
        send_request(CMD_COUNT, fresh_key(), 6'd63);
        send_request(CMD_READ,  64'd0, 6'd63);
        send_request(CMD_QUERY, tracker.stored_key[TABLE_ENTRIES - 1], 6'd0);
        wait_for_replies();
        repeat (100) @(posedge i_clk);

        $display({"Checked %0d replies: %0d count, %0d query, %0d read, ",
                  "%0d unused-command requests"},
                 tracker.replies_checked, tracker.per_command[CMD_COUNT],
                 tracker.per_command[CMD_QUERY], tracker.per_command[CMD_READ],
                 tracker.per_command[CMD_UNUSED]);
        $display("%0d dropped on a full table, %0d out-of-range reads, %0d counts held at max",
                 tracker.full_drops, tracker.bad_reads, tracker.saturated_hits);
        if (tracker.mismatches == 0 && tracker.pending_replies.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hdl/kfreq_pkg.sv
hdl/key_frequency_table_top.sv
verif/testbench.sv
